### sv/neighborhood_window_scan_assert.svh
// assertion macros used by the neighborhood window scan checker
`ifndef NEIGHBORHOOD_WINDOW_SCAN_ASSERT_SVH
`define NEIGHBORHOOD_WINDOW_SCAN_ASSERT_SVH

// clocked property, masked while reset is high
`define NWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define NWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/nws_pkg.sv
// shared constants, types and window functions for the neighborhood window scan
`timescale 1ns / 1ps
`default_nettype none

package nws_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = 3;
  localparam int MAX_RADIUS = (MAX_WINDOW - 1) / 2;
  localparam int RAD_BITS   = $clog2(MAX_RADIUS + 1);
  localparam int OFF_BITS   = $clog2(2 * MAX_RADIUS + 1);
  localparam int SUM_BITS   = COORD_BITS + 2;

  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_CIRCLE_MODE = 1'b1;

  typedef struct packed {
    logic load;
    logic advance;
    logic pend_load;
    logic out_push;
    logic out_last;
  } nws_cmd_t;

  typedef struct packed {
    logic cand_ok;
    logic scan_end;
    logic pend_valid;
    logic out_free;
  } nws_status_t;

  // radius = floor((size-1)/2), size clamped to the largest window
  function automatic logic [RAD_BITS-1:0] radius_of(input logic [SIZE_BITS-1:0] size);
    logic [SIZE_BITS-1:0] s;
    s = size;
    if (int'(s) > MAX_WINDOW) s = SIZE_BITS'(MAX_WINDOW);
    if (s == '0) return '0;
    return RAD_BITS'((s - SIZE_BITS'(1)) >> 1);
  endfunction

  // floor(sqrt(r*r - a*a)), zero when a exceeds r
  function automatic logic [RAD_BITS-1:0] half_width(input logic [RAD_BITS-1:0] r,
                                                     input logic [OFF_BITS-1:0] a);
    int hw;
    hw = 0;
    if (int'(a) <= int'(r)) begin
      for (int k = 0; k <= MAX_RADIUS; k++) begin
        if (k * k + int'(a) * int'(a) <= int'(r) * int'(r)) hw = k;
      end
    end
    return RAD_BITS'(hw);
  endfunction

  // half width of the row at offset row (0 is the top row)
  function automatic logic [RAD_BITS-1:0] row_half_width(input logic [RAD_BITS-1:0] r,
                                                         input logic [OFF_BITS-1:0] row,
                                                         input logic circ);
    logic [OFF_BITS-1:0] rr;
    logic [OFF_BITS-1:0] a;
    rr = OFF_BITS'(r);
    a  = (row > rr) ? (row - rr) : (rr - row);
    return circ ? half_width(r, a) : r;
  endfunction

endpackage

`default_nettype wire

### sv/nws_datapath.sv
// datapath: config registers, centre, scan counters, pending and output registers
`timescale 1ns / 1ps
`default_nettype none

module nws_datapath
  import nws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [SIZE_BITS-1:0]  cfg_data,
  input  wire logic [COORD_BITS-1:0] center_x,
  input  wire logic [COORD_BITS-1:0] center_y,
  input  wire logic                  out_ready,
  input  wire nws_cmd_t              cmd,
  output nws_status_t                status,
  output logic                       out_valid,
  output logic [COORD_BITS-1:0]      neighbor_x,
  output logic [COORD_BITS-1:0]      neighbor_y,
  output logic                       last
);

  logic [SIZE_BITS-1:0]  window_size;
  logic                  circle_mode;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [RAD_BITS-1:0]   radius;
  logic                  circ;
  logic [OFF_BITS-1:0]   row;
  logic [OFF_BITS-1:0]   col;
  logic                  pend_valid;
  logic [COORD_BITS-1:0] pend_x;
  logic [COORD_BITS-1:0] pend_y;

  logic [RAD_BITS-1:0]   load_radius;
  logic [RAD_BITS-1:0]   hw_cur;
  logic [RAD_BITS-1:0]   hw_next;
  logic [OFF_BITS-1:0]   rad_off;
  logic [OFF_BITS-1:0]   row_next;
  logic                  row_end;
  logic [SUM_BITS-1:0]   sum_x;
  logic [SUM_BITS-1:0]   sum_y;
  logic                  bad_x;
  logic                  bad_y;

  assign load_radius = radius_of(window_size);
  assign rad_off     = OFF_BITS'(radius);
  assign hw_cur      = row_half_width(radius, row, circ);
  assign row_next    = row + OFF_BITS'(1);
  assign hw_next     = row_half_width(radius, row_next, circ);
  assign row_end     = (col == rad_off + OFF_BITS'(hw_cur));

  // neighbour = centre + offset - radius, two guard bits catch both edges
  assign sum_x = SUM_BITS'(cx) + SUM_BITS'(col) - SUM_BITS'(radius);
  assign sum_y = SUM_BITS'(cy) + SUM_BITS'(row) - SUM_BITS'(radius);
  assign bad_x = sum_x[SUM_BITS-1] | sum_x[SUM_BITS-2];
  assign bad_y = sum_y[SUM_BITS-1] | sum_y[SUM_BITS-2];

  assign status.cand_ok    = !(row == rad_off && col == rad_off) && !bad_x && !bad_y;
  assign status.scan_end   = row_end && (row == OFF_BITS'({radius, 1'b0}));
  assign status.pend_valid = pend_valid;
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= SIZE_BITS'(3);
      circle_mode <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_SIZE: window_size <= cfg_data;
          CFG_CIRCLE_MODE: circle_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.out_push && cmd.out_last) begin
        pend_valid <= 1'b0;
      end
      if (cmd.out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx     <= center_x;
      cy     <= center_y;
      radius <= load_radius;
      circ   <= circle_mode;
      row    <= '0;
      col    <= OFF_BITS'(load_radius)
                - OFF_BITS'(row_half_width(load_radius, '0, circle_mode));
    end else if (cmd.advance) begin
      if (row_end) begin
        row <= row_next;
        col <= rad_off - OFF_BITS'(hw_next);
      end else begin
        col <= col + OFF_BITS'(1);
      end
    end
    if (cmd.pend_load) begin
      pend_x <= sum_x[COORD_BITS-1:0];
      pend_y <= sum_y[COORD_BITS-1:0];
    end
    if (cmd.out_push) begin
      neighbor_x <= pend_x;
      neighbor_y <= pend_y;
      last       <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

### sv/nws_ctrl.sv
// controller: sequences the accept, the window scan and the final flush
`timescale 1ns / 1ps
`default_nettype none

module nws_ctrl
  import nws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire nws_status_t status,
  output nws_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;
  logic   stall;

  // no beat is taken while reset is high
  assign in_ready = (state == ST_IDLE) && !rst;
  // a survivor needs the pending slot, which needs the output slot
  assign stall    = status.cand_ok && status.pend_valid && !status.out_free;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.advance   = 1'b1;
          cmd.pend_load = status.cand_ok;
          cmd.out_push  = status.cand_ok && status.pend_valid;
        end
      end
      ST_FLUSH: begin
        if (status.pend_valid && status.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!stall && status.scan_end) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (!status.pend_valid || status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/neighborhood_window_scan.sv
// top level of the neighborhood window scan: controller plus datapath
//
// usage
//   input channel (in_valid/in_ready) takes one beat per centre cell,
//   center_x and center_y. output channel (out_valid/out_ready) gives one
//   beat per neighbour cell, top row first, x rising within a row; the
//   centre and cells off either edge of the grid are skipped, and last
//   marks the final beat of a centre. a centre with no surviving
//   neighbour (e.g. window_size of one) gives no beat at all.
//   config: cfg_we/cfg_index/cfg_data, index 0 window_size, 1 circle_mode;
//   write only while the block is idle.
// timing
//   the scan counter visits one window cell per cycle unless a stall holds
//   it, so a centre goes through an accept, a scan of each cell of the
//   window (up to 49 for a 7 by 7 square) and a final flush. the first
//   beat shows up once a second survivor or the flush comes (one survivor
//   is held back so last can be set).
// reset and stalls
//   rst (synchronous, active high) empties the block and sets window_size
//   to 3, square mode. while a beat waits on out_ready the scan halts on
//   the next surviving cell; in_ready rises again once the final beat
//   sits in the output register, so the next centre overlaps its delivery.
`timescale 1ns / 1ps
`default_nettype none

module neighborhood_window_scan
  import nws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [SIZE_BITS-1:0]  cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] center_x,
  input  wire logic [COORD_BITS-1:0] center_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      neighbor_x,
  output logic [COORD_BITS-1:0]      neighbor_y,
  output logic                       last
);

  // commands from the controller, status back from the datapath
  nws_cmd_t    cmd;
  nws_status_t status;

  nws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // holds config, centre, scan position, one pending survivor and the output beat
  nws_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .center_x   (center_x),
    .center_y   (center_y),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .neighbor_x (neighbor_x),
    .neighbor_y (neighbor_y),
    .last       (last)
  );

endmodule

`default_nettype wire

### sv/nws_checker.sv
// port-level checker for the neighborhood window scan, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "neighborhood_window_scan_assert.svh"

module nws_checker
  import nws_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS-1:0] neighbor_x,
  input wire logic [COORD_BITS-1:0] neighbor_y,
  input wire logic                  last
);

  // output beat holds until taken
  `NWS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output beat dropped while stalled")
  `NWS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({neighbor_x, neighbor_y, last}), "stalled output beat changed")
  // a new centre is not taken while a burst is still under way
  `NWS_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input ready right after accepting a centre")
  `NWS_ASSERT(a_mid_burst_busy, out_valid && !last |-> !in_ready, "input ready while a burst is unfinished")

endmodule

bind neighborhood_window_scan nws_checker u_nws_checker (.*);

`default_nettype wire
